// ===== hdl/hdlc_df_pkg.sv =====
// Package for the HDLC bit deframer: result kinds and framing constants.
`default_nettype none
package hdlc_df_pkg;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_END        = 2'd1,
        KIND_MISALIGNED = 2'd2,
        KIND_OVERFLOW   = 2'd3
    } t_kind;

    localparam logic [7:0]  FLAG_PATTERN     = 8'h7e;
    localparam logic [15:0] COLLECTOR_EMPTY  = 16'hff00;
    localparam logic [15:0] BOUNDARY_PATTERN = 16'h01fc;
    localparam logic [7:0]  STUFF_MASK       = 8'hfe;
    localparam logic [7:0]  STUFF_PATTERN    = 8'h7c;
    localparam logic [11:0] MAX_BYTES_RESET  = 12'd1024;

endpackage
`default_nettype wire

// ===== hdl/hdlc_bit_deframer.sv =====
// HDLC bit deframer: flag hunt, zero-bit destuffing, byte assembly and frame reports.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_req_type, i_data_bit
//   output    out        o_out_valid / i_out_stall  o_result_kind, o_data_byte, o_frame_length
//   config    in         i_cfg_we                   i_cfg_data (max_frame_bytes)
//
// One bit per cycle while o_in_stall is low; each item is processed in the cycle it is
// accepted and its result, if any, is in the output register on the next cycle, or in the skid
// register when the output is stalled.
// A two-entry output (result register plus skid register) keeps o_in_stall registered;
// input stalls only while both entries hold results.
// Synchronous active-low reset clears the deframer state; max_frame_bytes returns to 1024.
`default_nettype none
module hdlc_bit_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [11:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic        i_data_bit,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_data_byte,
    output logic [11:0]      o_frame_length
);

    logic [11:0] r_max;
    logic [7:0]  r_win,  n_win;
    logic [15:0] r_coll, n_coll;
    logic [11:0] r_cnt,  n_cnt;
    logic        r_in_frame, n_in_frame;

    logic                 r_out_valid;
    hdlc_df_pkg::t_kind   r_out_kind;
    logic [7:0]           r_out_byte;
    logic [11:0]          r_out_len;
    logic                 r_sk_valid;
    hdlc_df_pkg::t_kind   r_sk_kind;
    logic [7:0]           r_sk_byte;
    logic [11:0]          r_sk_len;

    logic                 in_acc;
    logic                 res_valid;
    hdlc_df_pkg::t_kind   res_kind;
    logic [7:0]           res_byte;
    logic [11:0]          res_len;
    logic [7:0]           win_sh;
    logic [15:0]          coll_sh;
    logic                 out_free;

    assign in_acc   = i_in_valid && !r_sk_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        win_sh     = {i_data_bit, r_win[7:1]};
        coll_sh    = r_coll;
        n_win      = r_win;
        n_coll     = r_coll;
        n_cnt      = r_cnt;
        n_in_frame = r_in_frame;
        res_valid  = 1'b0;
        res_kind   = hdlc_df_pkg::KIND_DATA;
        res_byte   = 8'd0;
        res_len    = 12'd0;
        if (i_req_type) begin
            n_win      = 8'd0;
            n_coll     = hdlc_df_pkg::COLLECTOR_EMPTY;
            n_cnt      = 12'd0;
            n_in_frame = 1'b0;
        end else if (win_sh == hdlc_df_pkg::FLAG_PATTERN) begin
            n_win      = 8'd0;
            n_coll     = hdlc_df_pkg::COLLECTOR_EMPTY;
            n_cnt      = 12'd0;
            n_in_frame = 1'b1;
            if (r_in_frame) begin
                if (r_coll == hdlc_df_pkg::BOUNDARY_PATTERN) begin
                    if (r_cnt != 12'd0) begin
                        res_valid = 1'b1;
                        res_kind  = hdlc_df_pkg::KIND_END;
                        res_len   = r_cnt;
                    end
                end else begin
                    res_valid = 1'b1;
                    res_kind  = hdlc_df_pkg::KIND_MISALIGNED;
                end
            end
        end else begin
            n_win = win_sh;
            if (r_in_frame) begin
                if ((win_sh & hdlc_df_pkg::STUFF_MASK) != hdlc_df_pkg::STUFF_PATTERN) begin
                    coll_sh = {1'b0, r_coll[15:1]};
                    if (!i_data_bit) begin
                        coll_sh[7] = 1'b0;
                    end
                end
                n_coll = coll_sh;
                if (coll_sh[15:8] == 8'd0) begin
                    res_valid = 1'b1;
                    if (r_cnt < r_max) begin
                        res_kind = hdlc_df_pkg::KIND_DATA;
                        res_byte = coll_sh[7:0];
                        n_cnt    = r_cnt + 12'd1;
                        n_coll   = hdlc_df_pkg::COLLECTOR_EMPTY;
                    end else begin
                        res_kind   = hdlc_df_pkg::KIND_OVERFLOW;
                        n_win      = 8'd0;
                        n_coll     = hdlc_df_pkg::COLLECTOR_EMPTY;
                        n_cnt      = 12'd0;
                        n_in_frame = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= hdlc_df_pkg::MAX_BYTES_RESET;
            r_win      <= 8'd0;
            r_coll     <= hdlc_df_pkg::COLLECTOR_EMPTY;
            r_cnt      <= 12'd0;
            r_in_frame <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if (in_acc) begin
                r_win      <= n_win;
                r_coll     <= n_coll;
                r_cnt      <= n_cnt;
                r_in_frame <= n_in_frame;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_sk_valid) begin
                    r_out_valid <= 1'b1;
                    r_sk_valid  <= 1'b0;
                end else begin
                    r_out_valid <= in_acc && res_valid;
                end
            end else if (in_acc && res_valid) begin
                r_sk_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sk_valid) begin
                r_out_kind <= r_sk_kind;
                r_out_byte <= r_sk_byte;
                r_out_len  <= r_sk_len;
            end else begin
                r_out_kind <= res_kind;
                r_out_byte <= res_byte;
                r_out_len  <= res_len;
            end
        end else if (in_acc && res_valid) begin
            r_sk_kind <= res_kind;
            r_sk_byte <= res_byte;
            r_sk_len  <= res_len;
        end
    end

    assign o_in_stall     = r_sk_valid;
    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_data_byte    = r_out_byte;
    assign o_frame_length = r_out_len;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type) |=> (!r_in_frame && r_cnt == 12'd0 && r_win == 8'd0))
        else $error("restart did not clear deframer state");

    a_coll_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_coll[15:8] != 8'd0))
        else $error("completed byte left in collector");

    a_overflow_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_valid && res_kind == hdlc_df_pkg::KIND_OVERFLOW) |=> !r_in_frame)
        else $error("overflow did not return to flag hunt");

endmodule
`default_nettype wire

// ===== tb/hdlc_bit_deframer_tb.sv =====
// Testbench for hdlc_bit_deframer: queued bit driver, result monitor and deframer predictor.
`default_nettype none
module hdlc_bit_deframer_tb;

    typedef struct packed {
        logic restart;
        logic line_bit;
    } t_line_item;

    typedef struct {
        hdlc_df_pkg::t_kind kind;
        logic [7:0]         data_b;
        logic [11:0]        len;
    } t_deframe_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [11:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic        i_data_bit;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_data_byte;
    logic [11:0] o_frame_length;

    hdlc_bit_deframer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_data_bit     (i_data_bit),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_length (o_frame_length)
    );

    t_line_item      line_items[$];
    t_deframe_result pending_results[$];
    int              n_queued;
    int              n_accepted;
    int              n_errors;
    int              ones_run;
    int              send_idle_pct;
    int              recv_stall_pct;
    bit              in_fire;

    // predictor state
    logic [7:0]  flag_win;
    logic [15:0] collector;
    logic [11:0] frame_bytes;
    bit          in_frame;
    logic [11:0] max_bytes;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    task automatic clear_deframer();
        flag_win    = '0;
        collector   = hdlc_df_pkg::COLLECTOR_EMPTY;
        frame_bytes = '0;
        in_frame    = 1'b0;
    endtask

    task automatic add_result(input hdlc_df_pkg::t_kind k, input logic [7:0] b,
                              input logic [11:0] n);
        t_deframe_result r;
        r.kind   = k;
        r.data_b = b;
        r.len    = n;
        pending_results.push_back(r);
    endtask

    task automatic predict_bit(input logic restart, input logic b);
        bit          aligned;
        logic [11:0] cnt;
        if (restart) begin
            clear_deframer();
            return;
        end
        flag_win = {b, flag_win[7:1]};
        if (flag_win == hdlc_df_pkg::FLAG_PATTERN) begin
            aligned     = (collector == hdlc_df_pkg::BOUNDARY_PATTERN);
            cnt         = frame_bytes;
            flag_win    = '0;
            collector   = hdlc_df_pkg::COLLECTOR_EMPTY;
            frame_bytes = '0;
            if (!in_frame)
                in_frame = 1'b1;
            else if (!aligned)
                add_result(hdlc_df_pkg::KIND_MISALIGNED, 8'd0, 12'd0);
            else if (cnt != 0)
                add_result(hdlc_df_pkg::KIND_END, 8'd0, cnt);
            return;
        end
        if (!in_frame)
            return;
        // drop the zero after five ones
        if ((flag_win & hdlc_df_pkg::STUFF_MASK) != hdlc_df_pkg::STUFF_PATTERN) begin
            collector = collector >> 1;
            if (!b)
                collector[7] = 1'b0;
        end
        if (collector[15:8] != 8'd0)
            return;
        if (frame_bytes < max_bytes) begin
            add_result(hdlc_df_pkg::KIND_DATA, collector[7:0], 12'd0);
            frame_bytes = frame_bytes + 12'd1;
            collector   = hdlc_df_pkg::COLLECTOR_EMPTY;
        end else begin
            clear_deframer();
            add_result(hdlc_df_pkg::KIND_OVERFLOW, 8'd0, 12'd0);
        end
    endtask

    task automatic push_item(input logic restart, input logic b);
        t_line_item it;
        it.restart  = restart;
        it.line_bit = b;
        line_items.push_back(it);
        n_queued++;
    endtask

    task automatic push_flag();
        for (int i = 0; i < 8; i++)
            push_item(1'b0, hdlc_df_pkg::FLAG_PATTERN[i]);
    endtask

    // sender-side stuffing: a zero after every run of five ones
    task automatic push_line_bit(input logic b);
        push_item(1'b0, b);
        if (b) begin
            ones_run++;
            if (ones_run == 5) begin
                push_item(1'b0, 1'b0);
                ones_run = 0;
            end
        end else begin
            ones_run = 0;
        end
    endtask

    task automatic push_frame(input int nbytes, input int extra);
        logic [7:0] v;
        push_flag();
        ones_run = 0;
        repeat (nbytes) begin
            case ($urandom_range(7))
                0, 1: v = 8'hff;
                2: v = hdlc_df_pkg::FLAG_PATTERN;
                default: v = 8'($urandom_range(255));
            endcase
            for (int i = 0; i < 8; i++)
                push_line_bit(v[i]);
        end
        repeat (extra)
            push_line_bit(1'($urandom_range(1)));
        push_flag();
    endtask

    task automatic add_random_traffic(input int n_bits);
        int stop_at;
        int pick;
        int nbytes;
        int extra;
        stop_at = n_queued + n_bits;
        while (n_queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                nbytes = ($urandom_range(9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
                extra  = ($urandom_range(4) == 0) ? $urandom_range(1, 7) : 0;
                push_frame(nbytes, extra);
            end else if (pick < 78) begin
                repeat ($urandom_range(6, 10))
                    push_item(1'b0, 1'b1);
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 12))
                    push_item(1'b0, 1'($urandom_range(1)));
            end else begin
                push_item(1'b1, 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin : bit_driver
        t_line_item nxt;
        if (i_rst_n !== 1'b1) begin
            i_in_valid <= 1'b0;
            i_req_type <= 1'b0;
            i_data_bit <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (line_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = line_items.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= nxt.restart;
                i_data_bit <= nxt.line_bit;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_mon
        t_deframe_result exp_r;
        in_fire = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: expected no item, actual kind %0d byte %02h length %0d",
                             $time, o_result_kind, o_data_byte, o_frame_length);
                    n_errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_result_kind !== exp_r.kind) begin
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, exp_r.kind, o_result_kind);
                        n_errors++;
                    end
                    if (o_data_byte !== exp_r.data_b) begin
                        $display("%0t: data_byte expected %02h actual %02h",
                                 $time, exp_r.data_b, o_data_byte);
                        n_errors++;
                    end
                    if (o_frame_length !== exp_r.len) begin
                        $display("%0t: frame_length expected %0d actual %0d",
                                 $time, exp_r.len, o_frame_length);
                        n_errors++;
                    end
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                in_fire = 1'b1;
                predict_bit(i_req_type, i_data_bit);
                n_accepted++;
            end
        end
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int cfg_v;
        int seg_max[7];
        seg_max        = '{1024, 4095, 1, 0, 2, 0, 3};
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        n_queued       = 0;
        n_accepted     = 0;
        n_errors       = 0;
        ones_run       = 0;
        send_idle_pct  = 32;
        recv_stall_pct = 53;
        max_bytes      = hdlc_df_pkg::MAX_BYTES_RESET;
        clear_deframer();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int s = 0; s < 7; s++) begin
            if (s >= 5) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else if (s >= 3) begin
                send_idle_pct  = 53;
                recv_stall_pct = 32;
            end
            if (s != 0) begin
                wait_drained();
                repeat (4) @(posedge i_clk);
                cfg_v = (s == 5) ? $urandom_range(4, 40) : seg_max[s];
                @(negedge i_clk);
                i_cfg_we   <= 1'b1;
                i_cfg_data <= 12'(cfg_v);
                @(negedge i_clk);
                i_cfg_we   <= 1'b0;
                max_bytes = 12'(cfg_v);
            end
            if (s == 0) begin
                // restart, open, 0xff with a stuffed zero, close, empty frame
                push_item(1'b1, 1'b1);
                push_flag();
                ones_run = 0;
                repeat (8)
                    push_line_bit(1'b1);
                push_flag();
                push_flag();
            end
            add_random_traffic(155);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== hdlc_bit_deframer.f =====
hdl/hdlc_df_pkg.sv
hdl/hdlc_bit_deframer.sv
tb/hdlc_bit_deframer_tb.sv
